// File: design/bed_pkg.sv
// Shared types, character constants and helper functions for the
// backslash escape decoder. No dependencies.
package bed_pkg;

  localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
  localparam logic [7:0] CHAR_X         = 8'h78;
  localparam logic [7:0] CHAR_LOWER_A   = 8'h61;
  localparam logic [7:0] CHAR_ZERO      = 8'h30;
  localparam logic [7:0] CHAR_NINE      = 8'h39;
  localparam logic [7:0] CASE_FOLD      = 8'h20;  // 'a' - 'A'
  localparam logic [7:0] ALPHA_GAP      = 8'h07;  // 'A' - '9' - 1

  localparam logic [7:0] CTRL_BEL = 8'h07;
  localparam logic [7:0] CTRL_BS  = 8'h08;
  localparam logic [7:0] CTRL_TAB = 8'h09;
  localparam logic [7:0] CTRL_LF  = 8'h0A;
  localparam logic [7:0] CTRL_VT  = 8'h0B;
  localparam logic [7:0] CTRL_FF  = 8'h0C;
  localparam logic [7:0] CTRL_CR  = 8'h0D;

  typedef enum logic [3:0] {
    MODE_PLAIN = 4'b0001,
    MODE_ESC   = 4'b0010,
    MODE_HEX1  = 4'b0100,
    MODE_HEX2  = 4'b1000
  } bed_mode_t;

  typedef struct packed {
    logic [7:0] data;
    logic       has_char;
    logic       last;
  } bed_res_t;

  // Unchecked hex digit conversion, modulo 256.
  function automatic logic [7:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    if (v >= CHAR_LOWER_A) begin
      v = v - CASE_FOLD;
    end
    if (v > CHAR_NINE) begin
      v = v - CHAR_ZERO - ALPHA_GAP;
    end else begin
      v = v - CHAR_ZERO;
    end
    return v;
  endfunction

  function automatic logic [7:0] simple_escape(input logic [7:0] c);
    logic [7:0] r;
    case (c)
      8'h61:   r = CTRL_BEL;  // a
      8'h62:   r = CTRL_BS;   // b
      8'h66:   r = CTRL_FF;   // f
      8'h6E:   r = CTRL_LF;   // n
      8'h72:   r = CTRL_CR;   // r
      8'h74:   r = CTRL_TAB;  // t
      8'h76:   r = CTRL_VT;   // v
      default: r = c;
    endcase
    return r;
  endfunction

endpackage

// File: design/bed_in_stage.sv
// Input register of the escape decoder.
// Depends on nothing beyond the handshake signals from the top level.
module bed_in_stage (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  input  logic       advance,
  output logic       item_vld,
  output logic [7:0] item_byte,
  output logic       item_last
);

  logic       vld_r;
  logic [7:0] byte_r;
  logic       last_r;

  assign in_ready = !vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (in_ready) begin
      vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      byte_r <= in_byte;
      last_r <= in_last;
    end
  end

  assign item_vld  = vld_r;
  assign item_byte = byte_r;
  assign item_last = last_r;

endmodule

// File: design/bed_decode.sv
// Escape decode state machine and result logic.
// Depends on bed_pkg for mode codes, result type and conversions.
module bed_decode
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic [7:0] item_byte,
  input  logic       item_last,
  input  logic       advance,
  output logic       emit,
  output bed_res_t   res
);

  bed_mode_t  mode_r, mode_nxt;
  logic [3:0] high_r, high_nxt;
  logic [7:0] hex_v;
  logic [7:0] char_v;
  logic       char_ok;

  assign hex_v = hex_value(item_byte);

  always_comb begin
    mode_nxt = mode_r;
    high_nxt = high_r;
    char_ok  = 1'b0;
    char_v   = '0;
    case (mode_r)
      MODE_PLAIN: begin
        if (item_byte == CHAR_BACKSLASH && !item_last) begin
          mode_nxt = MODE_ESC;
        end else begin
          // a lone trailing backslash passes through as itself
          char_ok = 1'b1;
          char_v  = item_byte;
        end
      end
      MODE_ESC: begin
        if (item_byte == CHAR_X) begin
          mode_nxt = MODE_HEX1;
        end else begin
          char_ok  = 1'b1;
          char_v   = simple_escape(item_byte);
          mode_nxt = MODE_PLAIN;
        end
      end
      MODE_HEX1: begin
        high_nxt = hex_v[3:0];
        mode_nxt = MODE_HEX2;
      end
      MODE_HEX2: begin
        char_ok  = 1'b1;
        char_v   = {high_r, 4'b0000} | hex_v;
        high_nxt = '0;
        mode_nxt = MODE_PLAIN;
      end
      default: begin
        mode_nxt = MODE_PLAIN;
        high_nxt = '0;
      end
    endcase
    // end of string: drop any open escape
    if (item_last) begin
      mode_nxt = MODE_PLAIN;
      high_nxt = '0;
    end
  end

  assign emit         = char_ok || item_last;
  assign res.data     = char_ok ? char_v : 8'h00;
  assign res.has_char = char_ok;
  assign res.last     = item_last;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_PLAIN;
      high_r <= '0;
    end else if (advance) begin
      mode_r <= mode_nxt;
      high_r <= high_nxt;
    end
  end

  a_last_resets: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && item_last) |=> (mode_r == MODE_PLAIN && high_r == 4'h0))
    else $error("state not cleared after end of string");

  a_last_emits: assert property (@(posedge clk) disable iff (!rst_n)
    item_last |-> emit)
    else $error("end of string without a result");

  a_hex_steps: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && mode_r == MODE_HEX1 && !item_last) |=> mode_r == MODE_HEX2)
    else $error("hex escape did not advance to its second digit");

endmodule

// File: design/bed_out_stage.sv
// Result register of the escape decoder.
// Depends on bed_pkg for the result type.
module bed_out_stage
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  bed_res_t   res,
  output logic       full,
  output logic       out_item_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_end
);

  logic     vld_r;
  bed_res_t res_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (out_ready) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res_r <= res;
    end
  end

  assign full           = vld_r;
  assign out_item_valid = vld_r;
  assign out_byte       = res_r.data;
  assign out_valid      = res_r.has_char;
  assign out_end        = res_r.last;

endmodule

// File: design/backslash_escape_decoder_top.sv
// A byte passes the input register, then the result register. Throughput:
// one byte per cycle unless a held result waits for out_ready; decode is a
// single pass between registers. A non-last byte that closes no character
// (backslash, x, first hex digit) is consumed without a result transfer and
// never stalls on the result side. Reset (rst_n low, synchronous): both
// stages empty, decoder in plain text mode with a cleared high nibble.
module backslash_escape_decoder_top
  import bed_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic       in_last,
  output logic       out_item_valid,
  input  logic       out_ready,
  output logic [7:0] out_byte,
  output logic       out_valid,
  output logic       out_end
);

  logic       item_vld;
  logic [7:0] item_byte;
  logic       item_last;
  logic       emit;
  logic       out_full;
  logic       advance;
  bed_res_t   res;

  // Advance the held byte when it yields no result, or when the result
  // register is empty or being drained in this cycle.
  assign advance = item_vld && (!emit || !out_full || out_ready);

  // Hold incoming bytes; ready follows the advance of the held byte.
  bed_in_stage u_in (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_byte   (in_byte),
    .in_last   (in_last),
    .advance   (advance),
    .item_vld  (item_vld),
    .item_byte (item_byte),
    .item_last (item_last)
  );

  // Decode one byte per cycle against the escape state, while the held byte advances.
  bed_decode u_dec (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_byte (item_byte),
    .item_last (item_last),
    .advance   (advance),
    .emit      (emit),
    .res       (res)
  );

  // Register the result until the downstream transfer completes.
  bed_out_stage u_out (
    .clk            (clk),
    .rst_n          (rst_n),
    .load           (advance && emit),
    .res            (res),
    .full           (out_full),
    .out_item_valid (out_item_valid),
    .out_ready      (out_ready),
    .out_byte       (out_byte),
    .out_valid      (out_valid),
    .out_end        (out_end)
  );

endmodule
